### hdl/ssl_pkg.sv
package ssl_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int KEY_BITS    = 64;

  localparam int OP_W        = 3;
  localparam int KEY_IN_W    = 64;
  localparam int DEPTH_W     = 8;
  localparam int FUNC_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int INDEX_OUT_W = 9;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_FIND      = 3'd2,
    OP_LAST      = 3'd3,
    OP_SET_INIT  = 3'd4,
    OP_GET_INIT  = 3'd5,
    OP_GET_CONST = 3'd6,
    OP_NONE      = 3'd7
  } ssl_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_EMPTY     = 2'd3
  } ssl_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FIN
  } ssl_state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [DEPTH_W-1:0]  depth;
    logic [FUNC_W-1:0]   func;
    logic                cflag;
  } ssl_entry_t;

  localparam int ENTRY_W = KEY_BITS + DEPTH_W + FUNC_W + 1;

  typedef struct packed {
    logic capture;
    logic scan_clr;
    logic scan_run;
    logic scan_done;
    logic load;
  } ssl_cmd_t;

  typedef struct packed {
    logic lookup;
    logic empty;
    logic hit;
    logic miss;
    logic out_free;
  } ssl_stat_t;

endpackage

### hdl/ssl_ram.sv
module ssl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/ssl_ctrl.sv
module ssl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssl_pkg::ssl_stat_t stat_i,
  output ssl_pkg::ssl_cmd_t  cmd_o
);
  import ssl_pkg::*;

  ssl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat_i.lookup && !stat_i.empty) state_d = S_SCAN;
        else state_d = S_FIN;
      end
      S_SCAN: begin
        if (stat_i.hit || stat_i.miss) state_d = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_DECIDE: begin
        cmd_o.scan_clr = stat_i.lookup;
      end
      S_SCAN: begin
        if (stat_i.hit || stat_i.miss) cmd_o.scan_done = 1'b1;
        else cmd_o.scan_run = 1'b1;
      end
      S_FIN: begin
        cmd_o.load = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### hdl/ssl_datapath.sv
module ssl_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ssl_pkg::OP_W-1:0]           opcode_i,
  input  logic [ssl_pkg::KEY_IN_W-1:0]       key_i,
  input  logic [ssl_pkg::DEPTH_W-1:0]        scope_depth_i,
  input  logic [ssl_pkg::FUNC_W-1:0]         function_number_i,
  input  logic                               const_flag_i,
  input  ssl_pkg::ssl_cmd_t                  cmd_i,
  output ssl_pkg::ssl_stat_t                 stat_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ssl_pkg::STATUS_W-1:0]       status_o,
  output logic [ssl_pkg::INDEX_OUT_W-1:0]    entry_index_o,
  output logic                               is_initialized_o,
  output logic                               is_constant_o
);
  import ssl_pkg::*;

  ssl_op_e             op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic [FUNC_W-1:0]   func_q;
  logic                cflag_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] scan_addr_q, data_idx_q;
  logic             data_v_q;
  logic             found_q, found_init_q, found_const_q;
  logic [IDX_W-1:0] found_idx_q;

  logic                   out_valid_q;
  ssl_status_e            status_q, status_d;
  logic [INDEX_OUT_W-1:0] index_q, index_d;
  logic                   init_q, init_d, const_q, const_d;

  logic [ENTRY_W-1:0] rd_data;
  ssl_entry_t         rd_entry, wr_entry;
  logic               init_rd;
  logic               is_empty, is_full, match;
  logic [IDX_W-1:0]   count_idx, last_idx;
  logic               push_wr, set_wr;
  logic               init_wr_en;
  logic [IDX_W-1:0]   init_wr_addr;

  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CNT_W'(TABLE_DEPTH));
  assign count_idx = count_q[IDX_W-1:0];
  assign last_idx  = IDX_W'(count_q - CNT_W'(1));

  assign push_wr = cmd_i.load && (op_q == OP_PUSH) && !is_full;
  assign set_wr  = cmd_i.load && (op_q == OP_SET_INIT) && found_q;

  assign wr_entry.key   = key_q;
  assign wr_entry.depth = depth_q;
  assign wr_entry.func  = func_q;
  assign wr_entry.cflag = cflag_q;

  assign init_wr_en   = push_wr || set_wr;
  assign init_wr_addr = push_wr ? count_idx : found_idx_q;

  ssl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (push_wr),
    .wr_addr_i (count_idx),
    .wr_data_i (wr_entry),
    .rd_en_i   (cmd_i.scan_run),
    .rd_addr_i (scan_addr_q),
    .rd_data_o (rd_data)
  );

  ssl_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_init_ram (
    .clk_i     (clk_i),
    .wr_en_i   (init_wr_en),
    .wr_addr_i (init_wr_addr),
    .wr_data_i (set_wr),
    .rd_en_i   (cmd_i.scan_run),
    .rd_addr_i (scan_addr_q),
    .rd_data_o (init_rd)
  );

  assign rd_entry = rd_data;
  assign match = (rd_entry.depth <= depth_q) && (rd_entry.func == func_q) &&
                 (rd_entry.key == key_q);

  assign stat_o.lookup   = (op_q == OP_FIND) || (op_q == OP_SET_INIT) ||
                           (op_q == OP_GET_INIT) || (op_q == OP_GET_CONST);
  assign stat_o.empty    = is_empty;
  assign stat_o.hit      = data_v_q && match;
  assign stat_o.miss     = data_v_q && !match && (data_idx_q == last_idx);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // captured request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= ssl_op_e'(opcode_i);
      key_q   <= key_i[KEY_BITS-1:0];
      depth_q <= scope_depth_i;
      func_q  <= function_number_i;
      cflag_q <= const_flag_i;
    end
  end

  // scan pipeline: address issued in the cycle before the compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      data_v_q    <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      if (cmd_i.scan_clr) begin
        scan_addr_q <= '0;
        data_v_q    <= 1'b0;
        found_q     <= 1'b0;
      end else if (cmd_i.scan_run) begin
        scan_addr_q <= scan_addr_q + IDX_W'(1);
        data_v_q    <= 1'b1;
      end else if (cmd_i.scan_done) begin
        data_v_q <= 1'b0;
        found_q  <= match;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_run) begin
      data_idx_q <= scan_addr_q;
    end
    if (cmd_i.scan_done) begin
      found_idx_q   <= data_idx_q;
      found_init_q  <= init_rd;
      found_const_q <= rd_entry.cflag;
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = STS_OK;
    index_d  = '0;
    init_d   = 1'b0;
    const_d  = 1'b0;
    case (op_q)
      OP_PUSH: begin
        if (is_full) begin
          status_d = STS_FULL;
        end else begin
          index_d = INDEX_OUT_W'(count_idx);
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (is_empty) status_d = STS_EMPTY;
        else count_d = count_q - CNT_W'(1);
      end
      OP_LAST: begin
        if (is_empty) status_d = STS_EMPTY;
        else index_d = INDEX_OUT_W'(last_idx);
      end
      OP_FIND, OP_SET_INIT, OP_GET_INIT, OP_GET_CONST: begin
        if (!found_q) begin
          status_d = STS_NOT_FOUND;
        end else begin
          index_d = INDEX_OUT_W'(found_idx_q);
          init_d  = (op_q == OP_GET_INIT) && found_init_q;
          const_d = (op_q == OP_GET_CONST) && found_const_q;
        end
      end
      default: begin
        status_d = STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= status_d;
      index_q  <= index_d;
      init_q   <= init_d;
      const_q  <= const_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign entry_index_o    = index_q;
  assign is_initialized_o = init_q;
  assign is_constant_o    = const_q;

endmodule

### hdl/scoped_symbol_stack_lookup_core.sv
// Scoped symbol stack: push, pop, last index, and lookups (find, set/get
// initialized, get constant) that return the lowest entry matching key,
// function number and a depth at most the queried one. One item is handled
// at a time. Push, pop, last index and the unused opcode pass through the
// decide and finish states after acceptance, and the result is registered;
// the next item can be accepted once the result is loaded. A lookup scans
// the entries one per cycle through the single read port of the entry
// memory, between the decide and finish states; an empty table skips the
// scan. A result waiting at the output holds back the next item's
// completion, not its acceptance.
module scoped_symbol_stack_lookup_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ssl_pkg::OP_W-1:0]        opcode_i,
  input  logic [ssl_pkg::KEY_IN_W-1:0]    key_i,
  input  logic [ssl_pkg::DEPTH_W-1:0]     scope_depth_i,
  input  logic [ssl_pkg::FUNC_W-1:0]      function_number_i,
  input  logic                            const_flag_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ssl_pkg::STATUS_W-1:0]    status_o,
  output logic [ssl_pkg::INDEX_OUT_W-1:0] entry_index_o,
  output logic                            is_initialized_o,
  output logic                            is_constant_o
);
  import ssl_pkg::*;

  ssl_cmd_t  cmd;
  ssl_stat_t stat;

  ssl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ssl_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .opcode_i          (opcode_i),
    .key_i             (key_i),
    .scope_depth_i     (scope_depth_i),
    .function_number_i (function_number_i),
    .const_flag_i      (const_flag_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .entry_index_o     (entry_index_o),
    .is_initialized_o  (is_initialized_o),
    .is_constant_o     (is_constant_o)
  );

endmodule

### hdl/ssl_checker.sv
module ssl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [ssl_pkg::STATUS_W-1:0]    status_o,
  input logic [ssl_pkg::INDEX_OUT_W-1:0] entry_index_o,
  input logic                            is_initialized_o,
  input logic                            is_constant_o
);
  import ssl_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(entry_index_o))
    else $error("stalled result changed");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STS_OK) |->
      (entry_index_o == '0) && !is_initialized_o && !is_constant_o)
    else $error("nonzero fields on failed item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_initialized_o && is_constant_o))
    else $error("both flags reported");

endmodule

bind scoped_symbol_stack_lookup_core ssl_checker u_ssl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .entry_index_o    (entry_index_o),
  .is_initialized_o (is_initialized_o),
  .is_constant_o    (is_constant_o)
);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ssl_pkg::*;

  localparam int MAX_CYCLES = 5_000_000;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    ssl_op_e           op;
    logic [KEY_IN_W-1:0] key;
    logic [DEPTH_W-1:0]  depth;
    logic [FUNC_W-1:0]   func;
    logic                cflag;
  } sym_req_t;

  typedef struct {
    ssl_status_e            status;
    logic [INDEX_OUT_W-1:0] index;
    logic                   init;
    logic                   cnst;
  } sym_answer_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [OP_W-1:0]        opcode_i;
  logic [KEY_IN_W-1:0]    key_i;
  logic [DEPTH_W-1:0]     scope_depth_i;
  logic [FUNC_W-1:0]      function_number_i;
  logic                   const_flag_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [STATUS_W-1:0]    status_o;
  logic [INDEX_OUT_W-1:0] entry_index_o;
  logic                   is_initialized_o;
  logic                   is_constant_o;

  // shadow copy of the symbol stack
  logic [KEY_BITS-1:0] tbl_key   [TABLE_DEPTH];
  logic [DEPTH_W-1:0]  tbl_depth [TABLE_DEPTH];
  logic [FUNC_W-1:0]   tbl_func  [TABLE_DEPTH];
  logic                tbl_const [TABLE_DEPTH];
  logic                tbl_init  [TABLE_DEPTH];
  int                  sym_count;

  sym_answer_t expected_answers[$];
  logic [KEY_IN_W-1:0] key_pool[8];

  int mismatch_count;
  int answer_count;
  int cycle_count;
  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_left;

  scoped_symbol_stack_lookup_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .key_i            (key_i),
    .scope_depth_i    (scope_depth_i),
    .function_number_i(function_number_i),
    .const_flag_i     (const_flag_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .entry_index_o    (entry_index_o),
    .is_initialized_o (is_initialized_o),
    .is_constant_o    (is_constant_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) begin
      $display("%0t ns: %s", $time, what);
    end
    mismatch_count++;
  endtask

  function automatic sym_answer_t apply_symbol_op(sym_req_t rq);
    sym_answer_t a;
    logic        hit;
    int          at;
    a.status = STS_OK;
    a.index = '0;
    a.init = 1'b0;
    a.cnst = 1'b0;
    hit = 1'b0;
    at = 0;
    case (rq.op)
      OP_PUSH: begin
        if (sym_count >= TABLE_DEPTH) begin
          a.status = STS_FULL;
        end else begin
          tbl_key[sym_count] = rq.key[KEY_BITS-1:0];
          tbl_depth[sym_count] = rq.depth;
          tbl_func[sym_count] = rq.func;
          tbl_const[sym_count] = rq.cflag;
          tbl_init[sym_count] = 1'b0;
          a.index = INDEX_OUT_W'(sym_count);
          sym_count++;
        end
      end
      OP_POP: begin
        if (sym_count == 0) a.status = STS_EMPTY;
        else sym_count--;
      end
      OP_LAST: begin
        if (sym_count == 0) a.status = STS_EMPTY;
        else a.index = INDEX_OUT_W'(sym_count - 1);
      end
      OP_FIND, OP_SET_INIT, OP_GET_INIT, OP_GET_CONST: begin
        for (int i = 0; i < sym_count; i++) begin
          if (tbl_depth[i] <= rq.depth && tbl_func[i] == rq.func &&
              tbl_key[i] == rq.key[KEY_BITS-1:0]) begin
            hit = 1'b1;
            at = i;
            break;
          end
        end
        if (!hit) begin
          a.status = STS_NOT_FOUND;
        end else begin
          a.index = INDEX_OUT_W'(at);
          if (rq.op == OP_SET_INIT) tbl_init[at] = 1'b1;
          else if (rq.op == OP_GET_INIT) a.init = tbl_init[at];
          else if (rq.op == OP_GET_CONST) a.cnst = tbl_const[at];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk_i) begin
    sym_answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected item, status %0d index %0d",
                                  status_o, entry_index_o));
      end else begin
        want = expected_answers.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("item %0d: status %0d, want %0d",
                                    answer_count, status_o, want.status));
        if (entry_index_o !== want.index)
          report_mismatch($sformatf("item %0d: entry_index %0d, want %0d",
                                    answer_count, entry_index_o, want.index));
        if (is_initialized_o !== want.init)
          report_mismatch($sformatf("item %0d: is_initialized %0b, want %0b",
                                    answer_count, is_initialized_o, want.init));
        if (is_constant_o !== want.cnst)
          report_mismatch($sformatf("item %0d: is_constant %0b, want %0b",
                                    answer_count, is_constant_o, want.cnst));
      end
      answer_count++;
    end
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // entered and left just after a falling edge
  task automatic send_symbol_op(input sym_req_t rq);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= rq.op;
    key_i <= rq.key;
    scope_depth_i <= rq.depth;
    function_number_i <= rq.func;
    const_flag_i <= rq.cflag;
    do @(posedge clk_i); while (!in_ready_o);
    expected_answers.push_back(apply_symbol_op(rq));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_answers.size() != 0);
  endtask

  function automatic sym_req_t symbol_op(ssl_op_e op, logic [KEY_IN_W-1:0] key,
                                         logic [DEPTH_W-1:0] depth,
                                         logic [FUNC_W-1:0] func, logic cflag);
    sym_req_t rq;
    rq.op = op;
    rq.key = key;
    rq.depth = depth;
    rq.func = func;
    rq.cflag = cflag;
    return rq;
  endfunction

  function automatic sym_req_t random_fields(ssl_op_e op);
    return symbol_op(op, {$urandom, $urandom}, DEPTH_W'($urandom_range(255)),
                     FUNC_W'($urandom_range(255)), 1'($urandom_range(1)));
  endfunction

  function automatic sym_req_t make_push();
    sym_req_t rq;
    rq = random_fields(OP_PUSH);
    if ($urandom_range(99) < 70) rq.key = key_pool[$urandom_range(7)];
    if ($urandom_range(99) < 70) rq.depth = DEPTH_W'($urandom_range(7));
    if ($urandom_range(99) < 70) rq.func = FUNC_W'($urandom_range(3));
    return rq;
  endfunction

  // mostly a lookup that targets a stored entry, otherwise noise
  function automatic sym_req_t make_lookup(ssl_op_e op);
    sym_req_t rq;
    int       i;
    int       d;
    rq = random_fields(op);
    if (sym_count > 0 && $urandom_range(99) < 80) begin
      i = $urandom_range(sym_count - 1);
      d = int'(tbl_depth[i]) + $urandom_range(3);
      if ($urandom_range(99) < 10) d = 255;
      if (d > 255) d = 255;
      rq.key = KEY_IN_W'(tbl_key[i]);
      rq.func = tbl_func[i];
      rq.depth = DEPTH_W'(d);
    end else if ($urandom_range(1) == 1) begin
      rq.key = key_pool[$urandom_range(7)];
      rq.func = FUNC_W'($urandom_range(3));
    end
    return rq;
  endfunction

  function automatic ssl_op_e random_lookup_op();
    case ($urandom_range(3))
      0: return OP_FIND;
      1: return OP_SET_INIT;
      2: return OP_GET_INIT;
      default: return OP_GET_CONST;
    endcase
  endfunction

  function automatic sym_req_t random_symbol_op();
    int r;
    int push_w;
    r = $urandom_range(99);
    push_w = (sym_count < 8) ? 45 : (sym_count > 40) ? 15 : 30;
    if (r < 3) return random_fields(OP_NONE);
    if (r < 3 + push_w) return make_push();
    if (r < 21 + push_w) return random_fields(OP_POP);
    if (r < 26 + push_w) return random_fields(OP_LAST);
    return make_lookup(random_lookup_op());
  endfunction

  task automatic test_directed();
    logic [KEY_IN_W-1:0] ones;
    ones = '1;
    idle_pct = 0;
    stall_pct = 0;
    send_symbol_op(symbol_op(OP_POP, '0, '0, '0, 1'b0));
    send_symbol_op(symbol_op(OP_LAST, '0, '0, '0, 1'b0));
    send_symbol_op(symbol_op(OP_FIND, '0, '0, '0, 1'b0));
    send_symbol_op(symbol_op(OP_SET_INIT, ones, 8'hff, 8'hff, 1'b1));
    send_symbol_op(symbol_op(OP_NONE, ones, 8'hff, 8'hff, 1'b1));
    send_symbol_op(symbol_op(OP_PUSH, ones, 8'hff, 8'hff, 1'b1));
    send_symbol_op(symbol_op(OP_PUSH, '0, '0, '0, 1'b0));
    send_symbol_op(symbol_op(OP_PUSH, ones, 8'h00, 8'hff, 1'b0));
    // lowest matching index wins; a shallower query sees only the later entry
    send_symbol_op(symbol_op(OP_FIND, ones, 8'hff, 8'hff, 1'b0));
    send_symbol_op(symbol_op(OP_FIND, ones, 8'hfe, 8'hff, 1'b0));
    send_symbol_op(symbol_op(OP_FIND, ones, 8'hfe, 8'hfe, 1'b0));
    send_symbol_op(symbol_op(OP_GET_CONST, ones, 8'hff, 8'hff, 1'b0));
    send_symbol_op(symbol_op(OP_GET_INIT, ones, 8'hff, 8'hff, 1'b0));
    send_symbol_op(symbol_op(OP_SET_INIT, ones, 8'hff, 8'hff, 1'b0));
    send_symbol_op(symbol_op(OP_GET_INIT, ones, 8'hff, 8'hff, 1'b0));
    send_symbol_op(symbol_op(OP_GET_INIT, ones, 8'h0a, 8'hff, 1'b0));
    send_symbol_op(symbol_op(OP_FIND, '0, '0, '0, 1'b0));
    send_symbol_op(symbol_op(OP_SET_INIT, 64'h5, '0, '0, 1'b0));
    send_symbol_op(symbol_op(OP_LAST, '0, '0, '0, 1'b0));
    send_symbol_op(symbol_op(OP_POP, '0, '0, '0, 1'b0));
    send_symbol_op(symbol_op(OP_POP, '0, '0, '0, 1'b0));
    // push onto a popped slot; lookups still resolve to the initialized entry 0
    send_symbol_op(symbol_op(OP_PUSH, ones, 8'hff, 8'hff, 1'b0));
    send_symbol_op(symbol_op(OP_GET_INIT, ones, 8'hff, 8'hff, 1'b0));
    send_symbol_op(symbol_op(OP_GET_CONST, ones, 8'hff, 8'hff, 1'b0));
    send_symbol_op(symbol_op(OP_POP, '0, '0, '0, 1'b0));
    send_symbol_op(symbol_op(OP_POP, '0, '0, '0, 1'b0));
    drain_results();
  endtask

  task automatic test_full_table();
    int top;
    idle_pct = 27;
    stall_pct = 27;
    while (sym_count < TABLE_DEPTH) send_symbol_op(make_push());
    send_symbol_op(make_push());
    send_symbol_op(make_push());
    send_symbol_op(random_fields(OP_LAST));
    top = TABLE_DEPTH - 1;
    send_symbol_op(symbol_op(OP_FIND, KEY_IN_W'(tbl_key[top]), tbl_depth[top],
                             tbl_func[top], 1'b0));
    send_symbol_op(symbol_op(OP_SET_INIT, KEY_IN_W'(tbl_key[top]), 8'hff,
                             tbl_func[top], 1'b0));
    send_symbol_op(symbol_op(OP_GET_INIT, KEY_IN_W'(tbl_key[top]), 8'hff,
                             tbl_func[top], 1'b0));
    send_symbol_op(symbol_op(OP_GET_CONST, KEY_IN_W'(tbl_key[top]), 8'hff,
                             tbl_func[top], 1'b0));
    send_symbol_op(random_fields(OP_FIND));
    for (int i = 0; i < 6; i++) send_symbol_op(make_lookup(random_lookup_op()));
    send_symbol_op(random_fields(OP_POP));
    send_symbol_op(make_push());
    drain_results();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 6; i++) send_symbol_op(make_push());
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) send_symbol_op(random_symbol_op());
    drain_results();
    for (int i = 0; i < 4; i++) send_symbol_op(make_lookup(random_lookup_op()));
    drain_results();
  endtask

  task automatic test_random(input int in_idle, input int out_stall, input int n);
    idle_pct = in_idle;
    stall_pct = out_stall;
    while (sym_count > 0) send_symbol_op(random_fields(OP_POP));
    send_symbol_op(random_fields(OP_POP));
    send_symbol_op(random_fields(OP_LAST));
    for (int i = 0; i < n; i++) send_symbol_op(random_symbol_op());
    drain_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_NONE;
    key_i = '0;
    scope_depth_i = '0;
    function_number_i = '0;
    const_flag_i = 1'b0;
    sym_count = 0;
    mismatch_count = 0;
    answer_count = 0;
    cycle_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_backpressure();
    test_random(0, 0, 150);
    test_random(52, 0, 150);
    test_random(0, 52, 150);
    test_random(27, 27, 150);
    test_full_table();

    stall_pct = 0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### scoped_symbol_stack_lookup_core.f
hdl/ssl_pkg.sv
hdl/ssl_ram.sv
hdl/ssl_ctrl.sv
hdl/ssl_datapath.sv
hdl/scoped_symbol_stack_lookup_core.sv
hdl/ssl_checker.sv
bench/testbench.sv
